>>> sv/msdt_pkg.sv
// Shared types, codes and helpers for the deadline timer bank.
`default_nettype none
package msdt_pkg;
    localparam int SLOTS     = 16;
    localparam int SLOT_W    = 4;
    localparam int TIME_W    = 48;
    localparam int HALF_W    = 47;
    localparam int CNT_W     = 5;

    localparam logic [1:0] STAT_STOPPED   = 2'd0;
    localparam logic [1:0] STAT_RUNNING   = 2'd1;
    localparam logic [1:0] STAT_SUSPENDED = 2'd2;

    localparam logic [2:0] CMD_TICK    = 3'd0;
    localparam logic [2:0] CMD_ARM     = 3'd1;
    localparam logic [2:0] CMD_FORCE   = 3'd2;
    localparam logic [2:0] CMD_CANCEL  = 3'd3;
    localparam logic [2:0] CMD_SUSPEND = 3'd4;
    localparam logic [2:0] CMD_RESUME  = 3'd5;
    localparam logic [2:0] CMD_SET     = 3'd6;

    localparam logic [2:0] ERR_OK            = 3'd0;
    localparam logic [2:0] ERR_NOT_STOPPED   = 3'd1;
    localparam logic [2:0] ERR_NOT_ACTIVE    = 3'd2;
    localparam logic [2:0] ERR_NOT_RUNNING   = 3'd3;
    localparam logic [2:0] ERR_NOT_SUSPENDED = 3'd4;
    localparam logic [2:0] ERR_POOL_FULL     = 3'd5;

    localparam logic REG_MAX_ARMED   = 1'b0;
    localparam logic REG_HALF_PERIOD = 1'b1;

    typedef struct packed {
        logic              valid;
        logic [TIME_W-1:0] deadline;
        logic [SLOT_W-1:0] idx;
    } msdt_cand_t;

    typedef struct packed {
        logic              set_status;
        logic [1:0]        status;
        logic              set_deadline;
        logic [TIME_W-1:0] deadline;
        logic              set_reload;
        logic [TIME_W-1:0] reload;
        logic              set_remaining;
        logic [TIME_W-1:0] remaining;
        logic              set_rt;
        logic              rt;
        logic              clr_due;
    } msdt_wr_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                  input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction
endpackage
`default_nettype wire

>>> sv/multi_slot_deadline_timer.sv
// Top level: command sequencer, result buffering and the row of timer cells.
//  channel | direction | handshake           | payload
//  in      | input     | in_valid/in_ready   | cmd, slot, value, retrigger
//  out     | output    | out_valid/out_ready | kind, slot_id, error, slot_state,
//          |           |                     | time_value, last
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
// An item executes its command, marks the due slots, then runs one search
// through the chain of cells per expiry plus a final search that finds none.
// Results leave one at a time via an output register; a stalled output holds
// the sequencer. Reset stops every slot and clears time; cfg is always ready.
`default_nettype none
module multi_slot_deadline_timer
    import msdt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [2:0]        cmd,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [TIME_W-1:0] value,
    input  wire logic              retrigger,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   kind,
    output logic [SLOT_W-1:0]      slot_id,
    output logic [2:0]             error,
    output logic [1:0]             slot_state,
    output logic [TIME_W-1:0]      time_value,
    output logic                   last,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [HALF_W-1:0] cfg_data
);
    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_MARK, S_SCAN, S_FIRE} state_t;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] id;
        logic [2:0]        err;
        logic [1:0]        st;
        logic [TIME_W-1:0] tv;
    } res_t;

    state_t            state_reg;
    logic [SLOT_W-1:0] scan_cnt_reg;
    logic [CNT_W-1:0]  max_armed_reg;
    logic [HALF_W-1:0] half_reg;
    logic [TIME_W-1:0] now_reg, now_next;
    logic [2:0]        cmd_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [TIME_W-1:0] value_reg;
    logic              rt_in_reg;
    res_t              pend_reg, exec_res, fire_res;
    logic              out_valid_reg, out_last_reg;
    res_t              out_reg;

    msdt_wr_t          wr;
    logic [SLOT_W-1:0] wr_slot;
    logic              wr_en;
    logic [SLOTS-1:0]  sel;
    msdt_cand_t        cand [SLOTS];
    logic [1:0]        c_status [SLOTS];
    logic [TIME_W-1:0] c_deadline [SLOTS];
    logic [TIME_W-1:0] c_reload [SLOTS];
    logic [TIME_W-1:0] c_remaining [SLOTS];
    logic [SLOTS-1:0]  c_rt, c_due, run_vec;
    logic [CNT_W-1:0]  run_cnt;
    logic [TIME_W-1:0] limit;
    logic              out_free, mark, shift;
    msdt_cand_t        best;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !out_valid_reg || out_ready;
    assign mark      = (state_reg == S_MARK);
    assign shift     = (state_reg == S_SCAN);
    assign limit     = sat_add(now_reg, {1'b0, half_reg});
    assign best      = cand[SLOTS-1];
    assign run_cnt   = CNT_W'($countones(run_vec));

    genvar gi;
    generate
        for (gi = 0; gi < SLOTS; gi++)
        begin : g_cell
            msdt_cand_t cin;
            if (gi == 0)
            begin : g_head
                assign cin = '0;
            end
            else
            begin : g_link
                assign cin = cand[gi-1];
            end
            assign sel[gi]     = wr_en && (wr_slot == SLOT_W'(gi));
            assign run_vec[gi] = (c_status[gi] == STAT_RUNNING);
            msdt_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .idx      (SLOT_W'(gi)),
                .sel      (sel[gi]),
                .wr       (wr),
                .mark     (mark),
                .limit    (limit),
                .shift    (shift),
                .cand_in  (cin),
                .cand_out (cand[gi]),
                .status   (c_status[gi]),
                .deadline (c_deadline[gi]),
                .reload   (c_reload[gi]),
                .remaining(c_remaining[gi]),
                .rt       (c_rt[gi]),
                .due      (c_due[gi])
            );
        end
    endgenerate

    // command execution and expiry update
    always_comb
    begin
        logic             sv;
        logic [1:0]       cur;
        logic [CNT_W-1:0] cnt;
        logic [TIME_W-1:0] rem;
        sv       = ({1'b0, slot_reg} < (SLOT_W+1)'(SLOTS));
        cur      = c_status[slot_reg];
        cnt      = run_cnt;
        rem      = (c_deadline[slot_reg] > now_reg) ? c_deadline[slot_reg] - now_reg : '0;
        wr       = '0;
        wr_en    = 1'b0;
        wr_slot  = slot_reg;
        now_next = now_reg;
        exec_res = '0;
        fire_res = '0;

        if (state_reg == S_EXEC)
        begin
            wr_en = sv;
            case (cmd_reg)
                CMD_TICK: now_next = now_reg + value_reg;
                CMD_SET:  now_next = value_reg;
                CMD_ARM, CMD_FORCE:
                begin
                    exec_res.id = slot_reg;
                    if (!sv)
                        exec_res.err = ERR_POOL_FULL;
                    else if (cmd_reg == CMD_ARM && cur != STAT_STOPPED)
                        exec_res.err = ERR_NOT_STOPPED;
                    else
                    begin
                        if (cur == STAT_RUNNING)
                            cnt = run_cnt - CNT_W'(1);
                        wr.set_reload = 1'b1;
                        wr.reload     = value_reg;
                        wr.set_rt     = 1'b1;
                        wr.rt         = rt_in_reg;
                        wr.set_status = 1'b1;
                        if (cnt >= max_armed_reg)
                        begin
                            wr.status    = STAT_STOPPED;
                            exec_res.err = ERR_POOL_FULL;
                        end
                        else
                        begin
                            wr.status       = STAT_RUNNING;
                            wr.set_deadline = 1'b1;
                            wr.deadline     = sat_add(now_reg, value_reg);
                        end
                        exec_res.st = wr.status;
                    end
                    if (sv && exec_res.err == ERR_NOT_STOPPED)
                        exec_res.st = cur;
                end
                CMD_CANCEL:
                begin
                    exec_res.id = slot_reg;
                    if (!sv || cur == STAT_STOPPED)
                        exec_res.err = ERR_NOT_ACTIVE;
                    else
                    begin
                        wr.set_status = 1'b1;
                        wr.status     = STAT_STOPPED;
                    end
                    exec_res.st = STAT_STOPPED;
                end
                CMD_SUSPEND:
                begin
                    exec_res.id = slot_reg;
                    if (!sv || cur != STAT_RUNNING)
                    begin
                        exec_res.err = ERR_NOT_RUNNING;
                        exec_res.st  = sv ? cur : STAT_STOPPED;
                    end
                    else
                    begin
                        wr.set_status    = 1'b1;
                        wr.status        = STAT_SUSPENDED;
                        wr.set_remaining = 1'b1;
                        wr.remaining     = rem;
                        exec_res.st      = STAT_SUSPENDED;
                    end
                end
                CMD_RESUME:
                begin
                    exec_res.id = slot_reg;
                    if (!sv || cur != STAT_SUSPENDED)
                    begin
                        exec_res.err = ERR_NOT_SUSPENDED;
                        exec_res.st  = sv ? cur : STAT_STOPPED;
                    end
                    else if (cnt >= max_armed_reg)
                    begin
                        exec_res.err = ERR_POOL_FULL;
                        exec_res.st  = STAT_SUSPENDED;
                    end
                    else
                    begin
                        wr.set_status   = 1'b1;
                        wr.status       = STAT_RUNNING;
                        wr.set_deadline = 1'b1;
                        wr.deadline     = sat_add(now_reg, c_remaining[slot_reg]);
                        exec_res.st     = STAT_RUNNING;
                    end
                end
                default: now_next = now_reg;
            endcase
            exec_res.tv = (cmd_reg == CMD_SUSPEND && wr.set_remaining) ? rem : now_next;
        end
        else if (state_reg == S_FIRE && best.valid && out_free)
        begin
            wr_en         = 1'b1;
            wr_slot       = best.idx;
            wr.clr_due    = 1'b1;
            wr.set_status = 1'b1;
            // the firing slot no longer counts as running
            if (c_rt[best.idx] && (run_cnt - CNT_W'(1)) < max_armed_reg)
            begin
                wr.status       = STAT_RUNNING;
                wr.set_deadline = 1'b1;
                wr.deadline     = sat_add(now_reg, c_reload[best.idx]);
            end
            else
                wr.status = STAT_STOPPED;
        end
        fire_res.kind = 1'b1;
        fire_res.id   = best.idx;
        fire_res.err  = ERR_OK;
        fire_res.st   = wr.status;
        fire_res.tv   = now_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scan_cnt_reg  <= '0;
            max_armed_reg <= CNT_W'(SLOTS);
            half_reg      <= '0;
            now_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAX_ARMED)
                    max_armed_reg <= cfg_data[CNT_W-1:0];
                else
                    half_reg <= cfg_data;
            end
            if (state_reg == S_FIRE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_EXEC;
                S_EXEC:
                begin
                    now_reg   <= now_next;
                    state_reg <= S_MARK;
                end
                S_MARK:
                begin
                    scan_cnt_reg <= '0;
                    state_reg    <= S_SCAN;
                end
                S_SCAN:
                begin
                    scan_cnt_reg <= scan_cnt_reg + SLOT_W'(1);
                    if (scan_cnt_reg == SLOT_W'(SLOTS - 1))
                        state_reg <= S_FIRE;
                end
                S_FIRE:
                    if (out_free)
                    begin
                        scan_cnt_reg  <= '0;
                        state_reg     <= best.valid ? S_SCAN : S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            cmd_reg   <= cmd;
            slot_reg  <= slot;
            value_reg <= value;
            rt_in_reg <= retrigger;
        end
        if (state_reg == S_EXEC)
            pend_reg <= exec_res;
        if (state_reg == S_FIRE && out_free)
        begin
            out_reg      <= pend_reg;
            out_last_reg <= !best.valid;
            if (best.valid)
                pend_reg <= fire_res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign kind       = out_reg.kind;
    assign slot_id    = out_reg.id;
    assign error      = out_reg.err;
    assign slot_state = out_reg.st;
    assign time_value = out_reg.tv;
    assign last       = out_last_reg;

    // every due slot is fired before the sequencer returns to idle
    a_no_due_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (c_due == '0))
        else $error("due slot left after item");

    // the chosen slot is running and was marked due
    a_best_due: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIRE && best.valid) |->
            (c_due[best.idx] && c_status[best.idx] == STAT_RUNNING))
        else $error("search picked a slot that is not due");

    // an item is only taken once the previous final result is out of the sequencer
    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_EXEC))
        else $error("item accepted outside idle");
endmodule
`default_nettype wire

>>> sv/msdt_cell.sv
// One timer slot: its state plus one stage of the earliest-deadline search chain.
`default_nettype none
module msdt_cell
    import msdt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [SLOT_W-1:0] idx,
    input  wire logic              sel,
    input  wire msdt_wr_t          wr,
    input  wire logic              mark,
    input  wire logic [TIME_W-1:0] limit,
    input  wire logic              shift,
    input  wire msdt_cand_t        cand_in,
    output msdt_cand_t             cand_out,
    output logic [1:0]             status,
    output logic [TIME_W-1:0]      deadline,
    output logic [TIME_W-1:0]      reload,
    output logic [TIME_W-1:0]      remaining,
    output logic                   rt,
    output logic                   due
);
    logic [1:0]        status_reg;
    logic [TIME_W-1:0] deadline_reg, reload_reg, remaining_reg;
    logic              rt_reg, due_reg;
    msdt_cand_t        cand_reg, cand_next;

    always_comb
    begin
        cand_next = cand_in;
        // strictly less keeps the lower slot on a tie
        if (due_reg && (!cand_in.valid || deadline_reg < cand_in.deadline))
        begin
            cand_next.valid    = 1'b1;
            cand_next.deadline = deadline_reg;
            cand_next.idx      = idx;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            status_reg <= STAT_STOPPED;
            due_reg    <= 1'b0;
            cand_reg   <= '0;
        end
        else
        begin
            if (sel && wr.set_status)
                status_reg <= wr.status;
            if (mark)
                due_reg <= (status_reg == STAT_RUNNING) && (deadline_reg <= limit);
            else if (sel && wr.clr_due)
                due_reg <= 1'b0;
            if (shift)
                cand_reg <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sel && wr.set_deadline)
            deadline_reg <= wr.deadline;
        if (sel && wr.set_reload)
            reload_reg <= wr.reload;
        if (sel && wr.set_remaining)
            remaining_reg <= wr.remaining;
        if (sel && wr.set_rt)
            rt_reg <= wr.rt;
    end

    assign cand_out  = cand_reg;
    assign status    = status_reg;
    assign deadline  = deadline_reg;
    assign reload    = reload_reg;
    assign remaining = remaining_reg;
    assign rt        = rt_reg;
    assign due       = due_reg;
endmodule
`default_nettype wire

>>> tb/msdt_checker.sv
// Checker for the deadline timer bank: predicts results and compares them.
`default_nettype none
module msdt_checker
    import msdt_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic [2:0]        cmd,
    input  wire logic [SLOT_W-1:0] slot,
    input  wire logic [TIME_W-1:0] value,
    input  wire logic              retrigger,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic              kind,
    input  wire logic [SLOT_W-1:0] slot_id,
    input  wire logic [2:0]        error,
    input  wire logic [1:0]        slot_state,
    input  wire logic [TIME_W-1:0] time_value,
    input  wire logic              last,
    input  wire logic              cfg_valid,
    input  wire logic              cfg_ready,
    input  wire logic              cfg_index,
    input  wire logic [HALF_W-1:0] cfg_data,
    output int                     mismatches,
    output int                     outstanding,
    output int                     expiries_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot_id;
        logic [2:0]        error;
        logic [1:0]        slot_state;
        logic [TIME_W-1:0] time_value;
        logic              last;
    } timer_result_t;

    timer_result_t     expected_q[$];
    logic [TIME_W-1:0] cur_time;
    logic [CNT_W-1:0]  armed_cap;
    logic [HALF_W-1:0] tolerance;
    logic [1:0]        status_r[SLOTS];
    logic [TIME_W-1:0] deadline_r[SLOTS];
    logic [TIME_W-1:0] reload_r[SLOTS];
    logic [TIME_W-1:0] remaining_r[SLOTS];
    logic              retrig_r[SLOTS];

    function automatic logic [TIME_W-1:0] clamped_sum(input logic [TIME_W-1:0] a,
                                                      input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
    endfunction

    function automatic int running_slots();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
            if (status_r[i] == STAT_RUNNING)
                n++;
        return n;
    endfunction

    function automatic bit launch_slot(input int s, input logic [TIME_W-1:0] delay);
        if (running_slots() >= int'(armed_cap))
            return 1'b0;
        deadline_r[s] = clamped_sum(cur_time, delay);
        status_r[s] = STAT_RUNNING;
        return 1'b1;
    endfunction

    task automatic push_result(input logic k, input logic [SLOT_W-1:0] id,
                               input logic [2:0] e, input logic [1:0] st,
                               input logic [TIME_W-1:0] tv);
        timer_result_t r;
        r = '{kind: k, slot_id: id, error: e, slot_state: st, time_value: tv, last: 1'b0};
        expected_q.push_back(r);
    endtask

    task automatic predict_timer_item(input logic [2:0] c, input logic [SLOT_W-1:0] s,
                                      input logic [TIME_W-1:0] v, input logic rt);
        logic [2:0]        e;
        logic [1:0]        st;
        logic [SLOT_W-1:0] id;
        logic [TIME_W-1:0] tv;
        logic [TIME_W-1:0] fire_at;
        bit                rem_out;
        bit                due[SLOTS];
        int                best;
        e = ERR_OK;
        st = STAT_STOPPED;
        id = '0;
        rem_out = 1'b0;
        case (c)
            CMD_ARM, CMD_FORCE:
            begin
                id = s;
                if (c == CMD_ARM && status_r[s] != STAT_STOPPED)
                    e = ERR_NOT_STOPPED;
                else
                begin
                    status_r[s] = STAT_STOPPED;
                    reload_r[s] = v;
                    retrig_r[s] = rt;
                    if (!launch_slot(s, v))
                        e = ERR_POOL_FULL;
                end
                st = status_r[s];
            end
            CMD_CANCEL:
            begin
                id = s;
                if (status_r[s] == STAT_STOPPED)
                    e = ERR_NOT_ACTIVE;
                else
                    status_r[s] = STAT_STOPPED;
                st = status_r[s];
            end
            CMD_SUSPEND:
            begin
                id = s;
                if (status_r[s] != STAT_RUNNING)
                    e = ERR_NOT_RUNNING;
                else
                begin
                    remaining_r[s] = deadline_r[s] > cur_time ? deadline_r[s] - cur_time : '0;
                    status_r[s] = STAT_SUSPENDED;
                    rem_out = 1'b1;
                end
                st = status_r[s];
            end
            CMD_RESUME:
            begin
                id = s;
                if (status_r[s] != STAT_SUSPENDED)
                    e = ERR_NOT_SUSPENDED;
                else
                begin
                    status_r[s] = STAT_STOPPED;
                    if (!launch_slot(s, remaining_r[s]))
                    begin
                        status_r[s] = STAT_SUSPENDED;
                        e = ERR_POOL_FULL;
                    end
                end
                st = status_r[s];
            end
            CMD_TICK: cur_time = cur_time + v;
            CMD_SET:  cur_time = v;
            default: ;  // unknown code: a tick of zero
        endcase
        tv = rem_out ? remaining_r[s] : cur_time;
        push_result(1'b0, id, e, st, tv);

        fire_at = clamped_sum(cur_time, {1'b0, tolerance});
        for (int i = 0; i < SLOTS; i++)
            due[i] = status_r[i] == STAT_RUNNING && deadline_r[i] <= fire_at;
        forever
        begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
                if (due[i] && (best < 0 || deadline_r[i] < deadline_r[best]))
                    best = i;
            if (best < 0)
                break;
            due[best] = 1'b0;
            status_r[best] = STAT_STOPPED;
            if (retrig_r[best])
                void'(launch_slot(best, reload_r[best]));
            push_result(1'b1, SLOT_W'(best), ERR_OK, status_r[best], cur_time);
        end
        expected_q[expected_q.size()-1].last = 1'b1;
    endtask

    task automatic check_result();
        timer_result_t got;
        timer_result_t want;
        got = '{kind: kind, slot_id: slot_id, error: error, slot_state: slot_state,
                time_value: time_value, last: last};
        if (got.kind)
            expiries_seen++;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: kind %0d slot %0d err %0d st %0d time %0h last %0d",
                         got.kind, got.slot_id, got.error, got.slot_state,
                         got.time_value, got.last);
            return;
        end
        want = expected_q.pop_front();
        if (got !== want)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("%0t mismatch exp: kind %0d slot %0d err %0d st %0d time %0h last %0d",
                         $realtime, want.kind, want.slot_id, want.error, want.slot_state,
                         want.time_value, want.last);
                $display("    got: kind %0d slot %0d err %0d st %0d time %0h last %0d",
                         got.kind, got.slot_id, got.error, got.slot_state,
                         got.time_value, got.last);
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_q.delete();
            cur_time = '0;
            armed_cap = CNT_W'(16);
            tolerance = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                status_r[i] = STAT_STOPPED;
                deadline_r[i] = '0;
                reload_r[i] = '0;
                remaining_r[i] = '0;
                retrig_r[i] = 1'b0;
            end
            mismatches = 0;
            expiries_seen = 0;
            outstanding <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
                check_result();
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == REG_MAX_ARMED)
                    armed_cap = cfg_data[CNT_W-1:0];
                else
                    tolerance = cfg_data;
            end
            if (in_valid && in_ready)
                predict_timer_item(cmd, slot, value, retrigger);
            outstanding <= expected_q.size();
        end
    end
endmodule
`default_nettype wire

>>> tb/testbench.sv
// Top of the testbench: clock, reset, stimulus and verdict for the timer bank.
`default_nettype none
module testbench;
    import msdt_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [2:0] CMD_UNKNOWN = 3'd7;
    localparam int SETTLE_CYCLES = 400;

    logic              clk;
    logic              rst_n;
    logic              in_valid, in_ready;
    logic [2:0]        cmd;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] value;
    logic              retrigger;
    logic              out_valid, out_ready;
    logic              kind;
    logic [SLOT_W-1:0] slot_id;
    logic [2:0]        error;
    logic [1:0]        slot_state;
    logic [TIME_W-1:0] time_value;
    logic              last;
    logic              cfg_valid, cfg_ready;
    logic              cfg_index;
    logic [HALF_W-1:0] cfg_data;

    int mismatches, outstanding, expiries_seen;
    int items_sent;
    int settings_done;
    bit long_stall_done;

    multi_slot_deadline_timer uut (.*);

    msdt_checker chk (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #100_000_000;
        $display("testbench: errors");
        $finish;
    end

    function automatic int gap_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    endfunction

    function automatic logic [TIME_W-1:0] wide_rand();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[TIME_W-1:0];
    endfunction

    // receiver: random back-pressure, quiet stretches, one long hold-off
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (!long_stall_done && items_sent >= 220)
            begin
                out_ready <= 1'b0;
                repeat (1500) @(posedge clk);
                long_stall_done = 1'b1;
            end
            else if (items_sent % 100 < 15 || $urandom_range(0, 99) < 70)
                out_ready <= 1'b1;
            else
            begin
                out_ready <= 1'b0;
                repeat (gap_len()) @(posedge clk);
            end
        end
    end

    task automatic send_timer_cmd(input logic [2:0] c, input logic [SLOT_W-1:0] s,
                                  input logic [TIME_W-1:0] v, input logic rt);
        if (items_sent % 100 >= 40 && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            repeat (gap_len()) @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= c;
        slot <= s;
        value <= v;
        retrigger <= rt;
        forever
        begin
            @(negedge clk);
            if (in_ready)
                break;
        end
        @(posedge clk);
        items_sent++;
    endtask

    // drop valid and wait for every expected result plus the search tail
    task automatic drain();
        in_valid <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (outstanding == 0)
                break;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [HALF_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        forever
        begin
            @(negedge clk);
            if (cfg_ready)
                break;
        end
        @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_timer_cmd();
        int                r;
        logic [2:0]        c;
        logic [TIME_W-1:0] v;
        r = $urandom_range(0, 99);
        if (r < 28)      c = CMD_TICK;
        else if (r < 48) c = CMD_ARM;
        else if (r < 58) c = CMD_FORCE;
        else if (r < 68) c = CMD_CANCEL;
        else if (r < 80) c = CMD_SUSPEND;
        else if (r < 91) c = CMD_RESUME;
        else if (r < 96) c = CMD_SET;
        else             c = CMD_UNKNOWN;
        r = $urandom_range(0, 99);
        if (c == CMD_TICK)
            v = r < 70 ? TIME_W'($urandom_range(0, 100)) :
                r < 90 ? TIME_W'($urandom_range(0, 2000)) : wide_rand();
        else
            v = r < 70 ? TIME_W'($urandom_range(0, 300)) :
                r < 90 ? TIME_W'($urandom_range(0, 5000)) : wide_rand();
        send_timer_cmd(c, SLOT_W'($urandom_range(0, SLOTS - 1)), v, 1'($urandom));
    endtask

    logic [CNT_W-1:0]  cap_set[6]  = '{5'd2, 5'd1, 5'd0, 5'd31, 5'd4, 5'd16};
    logic [HALF_W-1:0] tol_set[6];

    initial
    begin
        tol_set = '{47'd0, 47'd10, 47'd0, {HALF_W{1'b1}}, 47'd100, 47'd0};
        items_sent = 0;
        settings_done = 0;
        long_stall_done = 1'b0;
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        cmd <= CMD_TICK;
        slot <= '0;
        value <= '0;
        retrigger <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_MAX_ARMED;
        cfg_data <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        write_reg(REG_MAX_ARMED, 47'd16);
        write_reg(REG_HALF_PERIOD, 47'd0);
        settings_done++;

        // directed: each code, error path and boundary
        send_timer_cmd(CMD_TICK, 4'd0, 48'd0, 1'b0);
        send_timer_cmd(CMD_ARM, 4'd0, 48'd10, 1'b0);
        send_timer_cmd(CMD_ARM, 4'd0, 48'd20, 1'b0);
        send_timer_cmd(CMD_FORCE, 4'd0, 48'd5, 1'b1);
        send_timer_cmd(CMD_CANCEL, 4'd3, 48'd0, 1'b0);
        send_timer_cmd(CMD_SUSPEND, 4'd3, 48'd0, 1'b0);
        send_timer_cmd(CMD_RESUME, 4'd0, 48'd0, 1'b0);
        send_timer_cmd(CMD_SUSPEND, 4'd0, 48'd0, 1'b0);
        send_timer_cmd(CMD_FORCE, 4'd0, 48'd7, 1'b1);  // force arm over suspended
        send_timer_cmd(CMD_SUSPEND, 4'd0, 48'd0, 1'b0);
        send_timer_cmd(CMD_RESUME, 4'd0, 48'd0, 1'b0);
        send_timer_cmd(CMD_TICK, 4'd0, 48'd7, 1'b0);   // fires, re-arms
        send_timer_cmd(CMD_ARM, 4'd15, {TIME_W{1'b1}}, 1'b0);
        send_timer_cmd(CMD_SET, 4'd0, 48'hFFFF_FFFF_FFF0, 1'b0);
        send_timer_cmd(CMD_TICK, 4'd0, 48'h20, 1'b0);  // time wraps
        send_timer_cmd(CMD_CANCEL, 4'd15, 48'd0, 1'b0);
        send_timer_cmd(CMD_UNKNOWN, 4'd9, 48'h5555_AAAA_5555, 1'b1);
        send_timer_cmd(CMD_SET, 4'd0, 48'd0, 1'b0);
        for (int i = 1; i < SLOTS; i++)
            if (i < 4)
                send_timer_cmd(CMD_ARM, SLOT_W'(i), 48'd50, 1'b1);
        send_timer_cmd(CMD_ARM, 4'd4, 48'd0, 1'b0);     // due at once
        send_timer_cmd(CMD_CANCEL, 4'd0, 48'd0, 1'b0);
        send_timer_cmd(CMD_TICK, 4'd0, 48'd100, 1'b0);  // ties go to lower slot
        drain();

        // phases over several register settings; switching with slots still
        // running lets a lowered limit refuse retrigger re-arms
        for (int p = 0; p < 6; p++)
        begin
            write_reg(REG_MAX_ARMED, {{(HALF_W-CNT_W){1'b0}}, cap_set[p]});
            write_reg(REG_HALF_PERIOD, tol_set[p]);
            settings_done++;
            repeat (80) random_timer_cmd();
            drain();
        end
        write_reg(REG_MAX_ARMED, 47'($urandom_range(1, 16)));
        write_reg(REG_HALF_PERIOD, 47'(wide_rand()));
        settings_done++;
        repeat (20) random_timer_cmd();
        drain();

        $display("summary: %0d commands over %0d register settings, %0d expiry events",
                 items_sent, settings_done, expiries_seen);
        if (mismatches == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end
endmodule
`default_nettype wire
